### src/uir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uir_pkg: shared types and constants for the update image receiver
// Field widths, command and status codes, and the byte-wise CRC-32 step.
// ----------------------------------------------------------------------------
package uir_pkg;

  // Field widths
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 10;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CODE_W     = 3;

  // Largest legal chunk in bytes
  localparam logic [WORD_W-1:0] MAX_CHUNK = 32'd512;

  // Reset value of the progress interval register
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd4096;

  // Reflected CRC-32 polynomial
  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DATA   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VERIFY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ABORT  = 2'd3;

  // Status kinds
  localparam logic [KIND_W-1:0] KIND_READY    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PROGRESS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUCCESS  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd3;

  // Error codes
  localparam logic [CODE_W-1:0] ERR_NONE         = 3'd0;
  localparam logic [CODE_W-1:0] ERR_BAD_SIZE     = 3'd0;
  localparam logic [CODE_W-1:0] ERR_NO_PARTITION = 3'd1;
  localparam logic [CODE_W-1:0] ERR_WRITE_FAILED = 3'd2;
  localparam logic [CODE_W-1:0] ERR_BAD_STATE    = 3'd3;
  localparam logic [CODE_W-1:0] ERR_CRC_MISMATCH = 3'd4;

  // One input transaction
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_byte;
    logic              chunk_first;
    logic              chunk_last;
    logic [LEN_W-1:0]  chunk_length;
    logic [WORD_W-1:0] image_size;
    logic [WORD_W-1:0] image_crc;
    logic              partition_ok;
    logic              begin_ok;
    logic              write_ok;
    logic              finish_ok;
  } uir_in_t;

  // One result transaction
  typedef struct packed {
    logic [KIND_W-1:0] status_kind;
    logic [CODE_W-1:0] error_code;
    logic [WORD_W-1:0] bytes_received;
  } uir_out_t;

  // Advance the CRC-32 (inverted in and out) by one byte
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = ~crc ^ {{(WORD_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
    end
    return ~c;
  endfunction

endpackage
`default_nettype wire

### src/uir_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uir_in_if: input channel of the update image receiver
// Valid/ready handshake carrying one command or data byte per transaction.
// ----------------------------------------------------------------------------
interface uir_in_if
  import uir_pkg::*;
();
  logic    valid;
  logic    ready;
  uir_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/uir_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uir_out_if: result channel of the update image receiver
// Valid/ready handshake carrying one status report per transaction.
// ----------------------------------------------------------------------------
interface uir_out_if
  import uir_pkg::*;
();
  logic     valid;
  logic     ready;
  uir_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/update_image_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// update_image_receiver_top: firmware image receiver session with CRC-32
// Opens a session on start, checks chunks and counts bytes, reports progress,
// verifies length and CRC, and closes the session on verify, abort or any error.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid / ready      uir_in_t  (command or data byte)
//   out_ch    source     valid / ready      uir_out_t (status report)
//   cfg_*     input      cfg_we             cfg_wdata (progress interval)
//
// One transaction is taken per cycle while in_ch.ready is high. The session
// update and CRC byte step are combinational from the accepted transaction
// into the session registers and the output register, so a status report
// appears in the cycle after its transaction. in_ch.ready is high while the
// output register is empty or being drained; a stalled out_ch holds at most
// one report and blocks input. Synchronous active-low reset closes the session
// and sets the interval to 4096.
// ----------------------------------------------------------------------------
module update_image_receiver_top
  import uir_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  uir_in_if.sink                     in_ch,
  uir_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [INTERVAL_W-1:0] cfg_wdata
);

  // Session registers
  logic                  session_active_r, session_active_nxt;
  logic                  dropping_r,       dropping_nxt;
  logic [WORD_W-1:0]     expected_total_r, expected_total_nxt;
  logic [WORD_W-1:0]     expected_crc_r,   expected_crc_nxt;
  logic [WORD_W-1:0]     received_r,       received_nxt;
  logic [WORD_W-1:0]     running_crc_r,    running_crc_nxt;
  logic [WORD_W-1:0]     last_reported_r,  last_reported_nxt;
  logic [INTERVAL_W-1:0] interval_r;

  // Output register
  logic     out_valid_r, out_valid_nxt;
  uir_out_t out_item_r,  out_item_nxt;

  // Per-transaction decode
  uir_in_t           item;
  logic              in_acc;
  logic              emit;
  logic              data_err;
  logic [CODE_W-1:0] data_code;
  logic [WORD_W:0]   chunk_end;
  logic [WORD_W-1:0] count_inc;
  logic [WORD_W-1:0] since_report;

  assign item   = in_ch.data;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc = in_ch.valid && in_ch.ready;

  assign chunk_end    = {1'b0, received_r} + {{(WORD_W+1-LEN_W){1'b0}}, item.chunk_length};
  assign count_inc    = received_r + 32'd1;
  assign since_report = count_inc - last_reported_r;

  // Check a data byte against the session
  always_comb begin
    data_err  = 1'b0;
    data_code = ERR_NONE;
    if (!session_active_r) begin
      data_err  = 1'b1;
      data_code = ERR_BAD_STATE;
    end else if (item.chunk_first) begin
      if (item.chunk_length == '0 ||
          {{(WORD_W-LEN_W){1'b0}}, item.chunk_length} > MAX_CHUNK) begin
        data_err  = 1'b1;
        data_code = ERR_BAD_SIZE;
      end else if (chunk_end > {1'b0, expected_total_r}) begin
        data_err  = 1'b1;
        data_code = ERR_BAD_SIZE;
      end else if (!item.write_ok) begin
        data_err  = 1'b1;
        data_code = ERR_WRITE_FAILED;
      end
    end else if (received_r >= expected_total_r) begin
      data_err  = 1'b1;
      data_code = ERR_BAD_SIZE;
    end
  end

  // Session update and status report for the accepted transaction
  always_comb begin
    session_active_nxt = session_active_r;
    dropping_nxt       = dropping_r;
    expected_total_nxt = expected_total_r;
    expected_crc_nxt   = expected_crc_r;
    received_nxt       = received_r;
    running_crc_nxt    = running_crc_r;
    last_reported_nxt  = last_reported_r;
    emit               = 1'b0;
    out_item_nxt       = '{status_kind: KIND_READY, error_code: ERR_NONE,
                           bytes_received: '0};

    case (item.mode)
      MODE_START: begin
        // close any old session, then open if the target is usable
        session_active_nxt = 1'b0;
        dropping_nxt       = 1'b0;
        expected_total_nxt = '0;
        expected_crc_nxt   = '0;
        received_nxt       = '0;
        running_crc_nxt    = '0;
        last_reported_nxt  = '0;
        emit               = 1'b1;
        if (!item.partition_ok) begin
          out_item_nxt.status_kind = KIND_ERROR;
          out_item_nxt.error_code  = ERR_NO_PARTITION;
        end else if (!item.begin_ok) begin
          out_item_nxt.status_kind = KIND_ERROR;
          out_item_nxt.error_code  = ERR_WRITE_FAILED;
        end else begin
          session_active_nxt = 1'b1;
          expected_total_nxt = item.image_size;
          expected_crc_nxt   = item.image_crc;
        end
      end
      MODE_VERIFY: begin
        dropping_nxt = 1'b0;
        emit         = 1'b1;
        if (!session_active_r) begin
          out_item_nxt.status_kind = KIND_ERROR;
          out_item_nxt.error_code  = ERR_BAD_STATE;
        end else begin
          // every outcome closes the session
          session_active_nxt = 1'b0;
          expected_total_nxt = '0;
          expected_crc_nxt   = '0;
          received_nxt       = '0;
          running_crc_nxt    = '0;
          last_reported_nxt  = '0;
          if (received_r != expected_total_r) begin
            out_item_nxt.status_kind = KIND_ERROR;
            out_item_nxt.error_code  = ERR_BAD_SIZE;
          end else if (running_crc_r != expected_crc_r) begin
            out_item_nxt.status_kind = KIND_ERROR;
            out_item_nxt.error_code  = ERR_CRC_MISMATCH;
          end else if (!item.finish_ok) begin
            out_item_nxt.status_kind = KIND_ERROR;
            out_item_nxt.error_code  = ERR_WRITE_FAILED;
          end else begin
            out_item_nxt.status_kind = KIND_SUCCESS;
          end
        end
      end
      MODE_DATA: begin
        if (dropping_r && !item.chunk_first) begin
          // drop the rest of a rejected chunk quietly
          if (item.chunk_last) begin
            dropping_nxt = 1'b0;
          end
        end else if (data_err) begin
          // close the session and drop the rest of this chunk
          session_active_nxt = 1'b0;
          dropping_nxt       = !item.chunk_last;
          expected_total_nxt = '0;
          expected_crc_nxt   = '0;
          received_nxt       = '0;
          running_crc_nxt    = '0;
          last_reported_nxt  = '0;
          emit               = 1'b1;
          out_item_nxt.status_kind = KIND_ERROR;
          out_item_nxt.error_code  = data_code;
        end else begin
          // accept the byte
          dropping_nxt    = 1'b0;
          running_crc_nxt = crc_byte(running_crc_r, item.data_byte);
          received_nxt    = count_inc;
          if (item.chunk_last &&
              (since_report >= {{(WORD_W-INTERVAL_W){1'b0}}, interval_r} ||
               count_inc == expected_total_r)) begin
            last_reported_nxt = count_inc;
            emit              = 1'b1;
            out_item_nxt.status_kind    = KIND_PROGRESS;
            out_item_nxt.bytes_received = count_inc;
          end
        end
      end
      default: begin
        // abort: close silently
        session_active_nxt = 1'b0;
        dropping_nxt       = 1'b0;
        expected_total_nxt = '0;
        expected_crc_nxt   = '0;
        received_nxt       = '0;
        running_crc_nxt    = '0;
        last_reported_nxt  = '0;
      end
    endcase
  end

  // Load a new report on accept, drain on out_ch handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Session and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_active_r <= 1'b0;
      dropping_r       <= 1'b0;
      expected_total_r <= '0;
      expected_crc_r   <= '0;
      received_r       <= '0;
      running_crc_r    <= '0;
      last_reported_r  <= '0;
      interval_r       <= INTERVAL_RESET;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        session_active_r <= session_active_nxt;
        dropping_r       <= dropping_nxt;
        expected_total_r <= expected_total_nxt;
        expected_crc_r   <= expected_crc_nxt;
        received_r       <= received_nxt;
        running_crc_r    <= running_crc_nxt;
        last_reported_r  <= last_reported_nxt;
      end
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the report payload until a new one is loaded
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

endmodule
`default_nettype wire

### dv/update_image_receiver_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// update_image_receiver_top_test: session-level test of the image receiver
// Drives start, data, verify and abort transactions through the input channel
// and predicts every status report with an in-bench session and CRC-32 model.
// Reports are checked field by field in order. A short directed part hits the
// corner cases. Random sessions with flaws and noise follow under several
// progress intervals, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module update_image_receiver_top_test;
  import uir_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;

  // Ways in which a random session departs from a clean transfer
  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_CRC,
    FLAW_SHORT,
    FLAW_WRITE_FAIL,
    FLAW_OVERRUN,
    FLAW_BAD_LEN,
    FLAW_ABORT,
    FLAW_RESTART,
    FLAW_NOISE,
    FLAW_FINISH_FAIL,
    FLAW_STRAY
  } session_flaw_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [INTERVAL_W-1:0] cfg_wdata;

  uir_in_if  in_ch ();
  uir_out_if out_ch ();

  update_image_receiver_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Session model state
  logic                  session_open;
  logic                  skip_rest;
  logic [WORD_W-1:0]     announced_size;
  logic [WORD_W-1:0]     announced_crc;
  logic [WORD_W-1:0]     byte_count;
  logic [WORD_W-1:0]     crc_acc;
  logic [WORD_W-1:0]     reported_at;
  logic [INTERVAL_W-1:0] report_gap;

  uir_out_t          pending_status[$];
  uir_out_t          head_status;
  logic [BYTE_W-1:0] image_bytes[$];

  int items_sent  = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic logic [WORD_W-1:0] crc_step(input logic [WORD_W-1:0] acc,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = acc ^ 32'hFFFF_FFFF;
    c[7:0] = c[7:0] ^ b;
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c ^ 32'hFFFF_FFFF;
  endfunction

  function automatic logic [WORD_W-1:0] image_check();
    logic [WORD_W-1:0] acc;
    acc = '0;
    foreach (image_bytes[i]) acc = crc_step(acc, image_bytes[i]);
    return acc;
  endfunction

  function automatic void clear_session();
    session_open   = 1'b0;
    skip_rest      = 1'b0;
    announced_size = '0;
    announced_crc  = '0;
    byte_count     = '0;
    crc_acc        = '0;
    reported_at    = '0;
  endfunction

  // Advance the session model by one transaction; return 1 when it reports
  function automatic bit predict_status(input uir_in_t t, output uir_out_t r);
    bit                bad;
    logic [CODE_W-1:0] code;
    logic [WORD_W:0]   reach;
    r = '0;
    case (t.mode)
      MODE_START: begin
        clear_session();
        r.status_kind = KIND_ERROR;
        if (!t.partition_ok) begin
          r.error_code = ERR_NO_PARTITION;
          return 1'b1;
        end
        if (!t.begin_ok) begin
          r.error_code = ERR_WRITE_FAILED;
          return 1'b1;
        end
        session_open   = 1'b1;
        announced_size = t.image_size;
        announced_crc  = t.image_crc;
        r.status_kind  = KIND_READY;
        return 1'b1;
      end
      MODE_ABORT: begin
        clear_session();
        return 1'b0;
      end
      MODE_VERIFY: begin
        skip_rest = 1'b0;
        r.status_kind = KIND_ERROR;
        if (!session_open) begin
          r.error_code = ERR_BAD_STATE;
          return 1'b1;
        end
        if (byte_count != announced_size) r.error_code = ERR_BAD_SIZE;
        else if (crc_acc != announced_crc) r.error_code = ERR_CRC_MISMATCH;
        else if (!t.finish_ok) r.error_code = ERR_WRITE_FAILED;
        else r.status_kind = KIND_SUCCESS;
        clear_session();
        return 1'b1;
      end
      default: begin
        // Swallow the tail of a rejected chunk
        if (skip_rest && !t.chunk_first) begin
          if (t.chunk_last) skip_rest = 1'b0;
          return 1'b0;
        end
        skip_rest = 1'b0;
        bad  = 1'b1;
        code = ERR_NONE;
        reach = {1'b0, byte_count} + t.chunk_length;
        if (!session_open) code = ERR_BAD_STATE;
        else if (t.chunk_first) begin
          if (t.chunk_length == 0 || t.chunk_length > MAX_CHUNK) code = ERR_BAD_SIZE;
          else if (reach > {1'b0, announced_size}) code = ERR_BAD_SIZE;
          else if (!t.write_ok) code = ERR_WRITE_FAILED;
          else bad = 1'b0;
        end else if (byte_count >= announced_size) code = ERR_BAD_SIZE;
        else bad = 1'b0;
        if (bad) begin
          clear_session();
          skip_rest     = !t.chunk_last;
          r.status_kind = KIND_ERROR;
          r.error_code  = code;
          return 1'b1;
        end
        crc_acc    = crc_step(crc_acc, t.data_byte);
        byte_count = byte_count + 1;
        if (t.chunk_last &&
            (byte_count - reported_at >= report_gap || byte_count == announced_size)) begin
          reported_at      = byte_count;
          r.status_kind    = KIND_PROGRESS;
          r.bytes_received = byte_count;
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Transaction builders
  // --------------------------------------------------------------------------

  function automatic uir_in_t random_item();
    uir_in_t t;
    t.mode         = MODE_W'($urandom_range(0, 3));
    t.data_byte    = BYTE_W'($urandom);
    t.chunk_first  = 1'($urandom);
    t.chunk_last   = 1'($urandom);
    t.chunk_length = LEN_W'($urandom_range(0, 1023));
    t.image_size   = $urandom;
    t.image_crc    = $urandom;
    t.partition_ok = 1'($urandom);
    t.begin_ok     = 1'($urandom);
    t.write_ok     = 1'($urandom);
    t.finish_ok    = 1'($urandom);
    return t;
  endfunction

  function automatic uir_in_t start_item(input logic [WORD_W-1:0] size,
                                         input logic [WORD_W-1:0] check,
                                         input bit pok, input bit bok);
    uir_in_t t;
    t = random_item();
    t.mode         = MODE_START;
    t.image_size   = size;
    t.image_crc    = check;
    t.partition_ok = pok;
    t.begin_ok     = bok;
    return t;
  endfunction

  function automatic uir_in_t data_item(input logic [BYTE_W-1:0] b, input bit first,
                                        input bit last, input logic [LEN_W-1:0] len,
                                        input bit wr_ok);
    uir_in_t t;
    t = random_item();
    t.mode         = MODE_DATA;
    t.data_byte    = b;
    t.chunk_first  = first;
    t.chunk_last   = last;
    t.chunk_length = len;
    // The writer status only counts on the first byte of a chunk
    t.write_ok     = first ? wr_ok : 1'($urandom);
    return t;
  endfunction

  function automatic uir_in_t verify_item(input bit fin_ok);
    uir_in_t t;
    t = random_item();
    t.mode      = MODE_VERIFY;
    t.finish_ok = fin_ok;
    return t;
  endfunction

  function automatic uir_in_t abort_item();
    uir_in_t t;
    t = random_item();
    t.mode = MODE_ABORT;
    return t;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Offer one transaction, hold it until accepted, then predict its report
  task automatic send_item(input uir_in_t t);
    uir_out_t r;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= t;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_status(t, r)) pending_status.push_back(r);
    items_sent++;
  endtask

  // Send the first 'sent' bytes of an n-byte chunk taken from the image
  task automatic send_chunk(input int from, input int n, input logic [LEN_W-1:0] len,
                            input bit wr_ok, input int sent);
    for (int i = 0; i < sent; i++)
      send_item(data_item(image_bytes[from + i], i == 0, i == n - 1, len, wr_ok));
  endtask

  // Drop valid and wait until every report is out and the pipeline is quiet
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [INTERVAL_W-1:0] value);
    hold_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    report_gap = value;
  endtask

  task automatic fill_image(input int size);
    image_bytes.delete();
    repeat (size) image_bytes.push_back(BYTE_W'($urandom));
  endtask

  // One session: start, chunks, verify, with at most one flaw injected
  task automatic run_session(input int size, input int max_len, input session_flaw_t flaw);
    logic [WORD_W-1:0] check;
    logic [LEN_W-1:0]  len;
    int                pos;
    int                n;
    int                sent;
    bit                wr_ok;
    bit                hit;
    bit                flaw_done;
    fill_image(size);
    check = image_check();
    if (flaw == FLAW_BAD_CRC) check = check ^ (32'd1 << $urandom_range(0, 31));
    send_item(start_item(size, check, 1'b1, 1'b1));
    pos = 0;
    flaw_done = 1'b0;
    while (pos < size) begin
      n     = $urandom_range(1, (size - pos < max_len) ? size - pos : max_len);
      len   = LEN_W'(n);
      wr_ok = 1'b1;
      sent  = n;
      hit   = flaw != FLAW_NONE && !flaw_done &&
              (pos + n == size || $urandom_range(0, 2) == 0);
      if (hit) begin
        flaw_done = 1'b1;
        case (flaw)
          FLAW_SHORT:      break;
          FLAW_WRITE_FAIL: wr_ok = 1'b0;
          FLAW_OVERRUN:    len = LEN_W'(size - pos + $urandom_range(1, 4));
          FLAW_BAD_LEN:    len = ($urandom_range(0, 1) != 0) ? LEN_W'(0)
                                                             : LEN_W'($urandom_range(513, 1023));
          FLAW_ABORT:      sent = $urandom_range(0, n - 1);
          FLAW_RESTART:    send_item(start_item($urandom_range(1, 64), $urandom, 1'b1, 1'b1));
          FLAW_NOISE:      send_item(random_item());
          default:         flaw_done = 1'b0;
        endcase
      end
      send_chunk(pos, n, len, wr_ok, sent);
      if (hit && flaw == FLAW_ABORT) send_item(abort_item());
      pos += n;
    end
    // Push one byte past the end of the image
    if (flaw == FLAW_STRAY)
      send_item(data_item(BYTE_W'($urandom), 1'b0, 1'($urandom),
                          LEN_W'($urandom_range(1, 512)), 1'b1));
    send_item(verify_item(flaw != FLAW_FINISH_FAIL));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_no_session();
    send_item(verify_item(1'b1));
    send_item(abort_item());
    // Only the first byte of the chunk is flagged, the rest is dropped
    image_bytes = '{8'h11, 8'h22, 8'h33};
    send_chunk(0, 3, LEN_W'(3), 1'b1, 3);
  endtask

  task automatic test_start_refusals();
    send_item(start_item(32'd16, 32'd0, 1'b0, 1'b0));
    send_item(start_item(32'd16, 32'd0, 1'b1, 1'b0));
  endtask

  task automatic test_empty_image();
    send_item(start_item(32'd0, 32'd0, 1'b1, 1'b1));
    send_item(verify_item(1'b1));
  endtask

  task automatic test_short_image();
    image_bytes = '{8'h00, 8'hFF, 8'hA5};
    send_item(start_item(32'd3, image_check(), 1'b1, 1'b1));
    send_chunk(0, 3, LEN_W'(3), 1'b1, 3);
    send_item(verify_item(1'b0));
  endtask

  task automatic test_chunk_rejects();
    image_bytes = '{8'h01, 8'h02};
    // Zero chunk length, then a length over the limit, then an overrun
    send_item(start_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_chunk(0, 2, LEN_W'(0), 1'b1, 2);
    send_item(start_item(32'd2, 32'd0, 1'b1, 1'b1));
    send_chunk(0, 1, LEN_W'(1023), 1'b1, 1);
    send_item(start_item(32'd2, 32'd0, 1'b1, 1'b1));
    send_chunk(0, 2, LEN_W'(512), 1'b1, 2);
  endtask

  task automatic test_stray_and_restart();
    image_bytes = '{8'h5A};
    send_item(start_item(32'd1, image_check(), 1'b1, 1'b1));
    send_chunk(0, 1, LEN_W'(1), 1'b1, 1);
    send_item(data_item(8'h5A, 1'b0, 1'b1, LEN_W'(1), 1'b1));
    // Start over an open session, then verify a short image
    send_item(start_item(32'd7, 32'd0, 1'b1, 1'b1));
    send_item(start_item(32'd2, 32'd0, 1'b1, 1'b1));
    send_chunk(0, 1, LEN_W'(1), 1'b1, 1);
    send_item(verify_item(1'b1));
  endtask

  task automatic test_largest_chunk();
    fill_image(512);
    send_item(start_item(32'd512, image_check(), 1'b1, 1'b1));
    send_chunk(0, 512, LEN_W'(512), 1'b1, 512);
    send_item(verify_item(1'b1));
  endtask

  task automatic test_random_sessions(input logic [INTERVAL_W-1:0] interval,
                                      input int budget, input bit allow_idle);
    int            stop_at;
    session_flaw_t flaw;
    write_interval(interval);
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if (allow_idle) begin
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
      end
      repeat ($urandom_range(0, 3)) send_item(random_item());
      flaw = ($urandom_range(0, 99) < 55) ? FLAW_NONE
                                          : session_flaw_t'($urandom_range(1, FLAW_STRAY));
      if ($urandom_range(0, 9) == 0) run_session($urandom_range(60, 200), 64, flaw);
      else run_session($urandom_range(0, 48), $urandom_range(1, 16), flaw);
      if ($urandom_range(0, 7) == 0) hold_until_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result channel: random stall bursts
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  end

  // Compare each accepted report with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_status.size() == 0) begin
        $error("unexpected report: status_kind %0d error_code %0d bytes_received %0d",
               out_ch.data.status_kind, out_ch.data.error_code, out_ch.data.bytes_received);
        error_count++;
      end else begin
        head_status = pending_status.pop_front();
        if (out_ch.data.status_kind !== head_status.status_kind) begin
          $error("status_kind: expected %0d, actual %0d",
                 head_status.status_kind, out_ch.data.status_kind);
          error_count++;
        end
        if (out_ch.data.error_code !== head_status.error_code) begin
          $error("error_code: expected %0d, actual %0d",
                 head_status.error_code, out_ch.data.error_code);
          error_count++;
        end
        if (out_ch.data.bytes_received !== head_status.bytes_received) begin
          $error("bytes_received: expected %0d, actual %0d",
                 head_status.bytes_received, out_ch.data.bytes_received);
          error_count++;
        end
      end
    end
  end

  // Stop a run that makes no progress on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    report_gap  = INTERVAL_RESET;
    clear_session();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct   = 20;
    stall_pct = 20;
    test_no_session();
    test_start_refusals();
    test_empty_image();
    test_short_image();
    test_chunk_rejects();
    test_stray_and_restart();

    gap_pct   = 10;
    stall_pct = 10;
    test_largest_chunk();

    test_random_sessions(16'd1, 230, 1'b1);
    test_random_sessions(16'd0, 230, 1'b1);
    test_random_sessions(16'd65535, 200, 1'b1);
    test_random_sessions(INTERVAL_W'($urandom_range(2, 40)), 260, 1'b1);

    // Closing stretch runs at full rate on both sides
    gap_pct   = 0;
    stall_pct = 0;
    test_random_sessions(INTERVAL_W'($urandom_range(8, 64)), 200, 1'b0);

    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
